// ----- hw/rtl/uct_pkg.sv -----
// ----------------------------------------------------------------------------
// uct_pkg
// Shared types, codes and constants of the user credential table.
// ----------------------------------------------------------------------------
package uct_pkg;

  localparam int MaxUsersDef = 16;
  localparam int IdCharsDef  = 8;
  localparam int PinCharsDef = 5;

  localparam int ReqW  = 3;
  localparam int IdW   = 64;
  localparam int PinW  = 40;
  localparam int CatW  = 8;
  localparam int StatW = 2;

  localparam logic [CatW-1:0] AdminCategory = 8'd0;

  typedef enum logic [ReqW-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_VERIFY_ID  = 3'd2,
    OP_VERIFY_PIN = 3'd3,
    OP_READ_CAT   = 3'd4,
    OP_CHANGE_PIN = 3'd5,
    OP_NONE       = 3'd6
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUP       = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_SCAN,
    BK_ACT,
    BK_MOVE_WR,
    BK_RESP
  } back_state_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t             op;
    logic [IdW-1:0]  id;
    logic [PinW-1:0] pin;
    logic [CatW-1:0] cat;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PinW-1:0] pin;
    logic [CatW-1:0] cat;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  function automatic logic [63:0] chars_mask(input int n);
    logic [63:0] m;
    m = '1;
    if (n < 8) begin
      m = (64'd1 << (8 * n)) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [63:0] admin_id(input int n);
    logic [7:0]  chars [8];
    logic [63:0] v;
    chars = '{8'h36, 8'h30, 8'h36, 8'h31, 8'h32, 8'h36, 8'h38, 8'h33};
    v = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        v = {v[55:0], chars[k]};
      end
    end
    return v & chars_mask(n);
  endfunction

  function automatic logic [63:0] admin_pin(input int n);
    logic [7:0]  chars [5];
    logic [63:0] v;
    chars = '{8'h35, 8'h35, 8'h38, 8'h34, 8'h35};
    v = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        v = {v[55:0], (k < 5) ? chars[k] : 8'h00};
      end
    end
    return v & chars_mask(n);
  endfunction

endpackage

// ----- hw/rtl/uct_if.sv -----
// ----------------------------------------------------------------------------
// uct_req_if / uct_rsp_if
// Valid/ready channels for requests and results of the credential table.
// ----------------------------------------------------------------------------
interface uct_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] user_id;
  logic [39:0] user_pin;
  logic [7:0]  user_category;

  modport source (output valid, req_type, user_id, user_pin, user_category,
                  input ready);
  modport sink   (input valid, req_type, user_id, user_pin, user_category,
                  output ready);
endinterface

interface uct_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       match;
  logic [7:0] category;

  modport source (output valid, status, match, category, input ready);
  modport sink   (input valid, status, match, category, output ready);
endinterface

// ----- hw/rtl/uct_ram.sv -----
// ----------------------------------------------------------------------------
// uct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/uct_front.sv -----
// ----------------------------------------------------------------------------
// uct_front
// Accepts requests, decodes the operation, trims ID and PIN to their
// character counts and queues the item for the back end.
// ----------------------------------------------------------------------------
module uct_front import uct_pkg::*; #(
  parameter int ID_CHARS  = IdCharsDef,
  parameter int PIN_CHARS = PinCharsDef
) (
  input  logic      clk,
  input  logic      rst,
  uct_req_if.sink   req,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);

  localparam logic [IdW-1:0]  IdMask  = chars_mask(ID_CHARS);
  localparam logic [PinW-1:0] PinMask = PinW'(chars_mask(PIN_CHARS));

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd     = '0;
    in_cmd.op  = OP_NONE;
    if (req.req_type inside {[OP_ADD:OP_CHANGE_PIN]}) begin
      in_cmd.op = op_t'(req.req_type);
    end
    in_cmd.id  = req.user_id & IdMask;
    in_cmd.pin = req.user_pin & PinMask;
    in_cmd.cat = req.user_category;
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ----- hw/rtl/uct_back.sv -----
// ----------------------------------------------------------------------------
// uct_back
// Executes queued requests: scans the occupied slots one per cycle, then
// adds, removes (swap with last), checks or updates the found entry.
// ----------------------------------------------------------------------------
module uct_back import uct_pkg::*; #(
  parameter int MAX_USERS = MaxUsersDef,
  parameter int ID_CHARS  = IdCharsDef,
  parameter int PIN_CHARS = PinCharsDef
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  uct_rsp_if.source rsp
);

  localparam int IdxW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CntW = $clog2(MAX_USERS + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_USERS);

  localparam entry_t AdminEntry = '{
    id:  admin_id(ID_CHARS),
    pin: PinW'(admin_pin(PIN_CHARS)),
    cat: AdminCategory
  };

  back_state_t     state, state_next;
  cmd_t            cur, cur_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] addr, addr_next;
  logic            chk_vld, chk_vld_next;
  logic [IdxW-1:0] chk_idx, chk_idx_next;
  logic            found, found_next;
  logic [IdxW-1:0] slot, slot_next;
  logic [PinW-1:0] hit_pin, hit_pin_next;
  logic [CatW-1:0] hit_cat, hit_cat_next;
  status_t         res_status, res_status_next;
  logic            res_match, res_match_next;
  logic [CatW-1:0] res_cat, res_cat_next;
  logic            out_load;
  logic            hit;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_rdata;

  uct_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_USERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit = chk_vld && (ram_rdata.id == cur.id);

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    count_next      = count;
    addr_next       = addr;
    chk_vld_next    = chk_vld;
    chk_idx_next    = chk_idx;
    found_next      = found;
    slot_next       = slot;
    hit_pin_next    = hit_pin;
    hit_cat_next    = hit_cat;
    res_status_next = res_status;
    res_match_next  = res_match;
    res_cat_next    = res_cat;
    cmd_ready       = 1'b0;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = slot;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = addr[IdxW-1:0];

    case (state)
      BK_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = AdminEntry;
        state_next = BK_IDLE;
      end
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_next        = cmd;
          addr_next       = '0;
          chk_vld_next    = 1'b0;
          found_next      = 1'b0;
          res_status_next = ST_OK;
          res_match_next  = 1'b0;
          res_cat_next    = '0;
          if (cmd.op == OP_NONE) begin
            state_next = BK_RESP;
          end else if (cmd.op == OP_ADD && count >= MaxCount) begin
            res_status_next = ST_FULL;
            state_next      = BK_RESP;
          end else begin
            state_next = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        // one read issued per cycle; compare checks the registered data of the last read
        if (hit) begin
          found_next   = 1'b1;
          slot_next    = chk_idx;
          hit_pin_next = ram_rdata.pin;
          hit_cat_next = ram_rdata.cat;
          chk_vld_next = 1'b0;
          state_next   = BK_ACT;
        end else if (addr < count) begin
          ram_re       = 1'b1;
          addr_next    = addr + CntW'(1);
          chk_vld_next = 1'b1;
          chk_idx_next = addr[IdxW-1:0];
        end else if (chk_vld) begin
          chk_vld_next = 1'b0;
        end else begin
          state_next = BK_ACT;
        end
      end
      BK_ACT: begin
        state_next = BK_RESP;
        case (cur.op)
          OP_ADD: begin
            if (found) begin
              res_status_next = ST_DUP;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count[IdxW-1:0];
              ram_wdata  = '{id: cur.id, pin: cur.pin, cat: cur.cat};
              count_next = count + CntW'(1);
            end
          end
          OP_REMOVE: begin
            if (found) begin
              ram_re     = 1'b1;
              ram_raddr  = IdxW'(count - CntW'(1));
              state_next = BK_MOVE_WR;
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end
          OP_VERIFY_ID: begin
            res_match_next  = found;
            res_status_next = found ? ST_OK : ST_NOT_FOUND;
          end
          OP_VERIFY_PIN: begin
            if (found) begin
              res_match_next = (hit_pin == cur.pin);
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end
          OP_READ_CAT: begin
            if (found) begin
              res_cat_next = hit_cat;
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end
          OP_CHANGE_PIN: begin
            if (found) begin
              ram_we    = 1'b1;
              ram_waddr = slot;
              ram_wdata = '{id: cur.id, pin: cur.pin, cat: hit_cat};
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      BK_MOVE_WR: begin
        // last entry fills the freed slot
        ram_we     = 1'b1;
        ram_waddr  = slot;
        ram_wdata  = ram_rdata;
        count_next = count - CntW'(1);
        state_next = BK_RESP;
      end
      BK_RESP: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_INIT;
      count     <= CntW'(1);
      chk_vld   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    addr       <= addr_next;
    chk_idx    <= chk_idx_next;
    found      <= found_next;
    slot       <= slot_next;
    hit_pin    <= hit_pin_next;
    hit_cat    <= hit_cat_next;
    res_status <= res_status_next;
    res_match  <= res_match_next;
    res_cat    <= res_cat_next;
    if (out_load) begin
      rsp.status   <= res_status;
      rsp.match    <= res_match;
      rsp.category <= res_cat;
    end
  end

endmodule

// ----- hw/rtl/user_credential_table_core.sv -----
// ----------------------------------------------------------------------------
// user_credential_table_core
// Credential table with add, swap-remove, ID/PIN check, category read and
// PIN change.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, user_id, user_pin, user_category
//   rsp      out  valid/ready    status, match, category
//
// The back end scans the occupied slots of the table RAM one slot per cycle
// through its single read port; the scan stops at a hit. A remove then moves
// the last entry into the freed slot. Items pass the front-end queue first.
// Codes six and seven and a full-table add skip the scan. After reset the
// BK_INIT state writes the admin entry; requests queue meanwhile. A two-item
// queue and the result register let req and rsp stall independently.
// ----------------------------------------------------------------------------
module user_credential_table_core import uct_pkg::*; #(
  parameter int MAX_USERS = MaxUsersDef,
  parameter int ID_CHARS  = IdCharsDef,
  parameter int PIN_CHARS = PinCharsDef
) (
  input  logic      clk,
  input  logic      rst,
  uct_req_if.sink   req,
  uct_rsp_if.source rsp
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  uct_front #(
    .ID_CHARS  (ID_CHARS),
    .PIN_CHARS (PIN_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  uct_back #(
    .MAX_USERS (MAX_USERS),
    .ID_CHARS  (ID_CHARS),
    .PIN_CHARS (PIN_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp)
  );

endmodule
